// ===== rtl/rectangle_pair_relation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Rectangle pair relation unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_PAIR_RELATION_UNIT_DEFINES_SVH
`define RECTANGLE_PAIR_RELATION_UNIT_DEFINES_SVH

// Check a condition at every clock edge out of reset.
`define RPR_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rpr assertion failed");

// Check that a condition in one cycle implies another in the next.
`define RPR_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rpr assertion failed");

`endif

// ===== rtl/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation package
// Widths, transaction types and stage records shared by the pipeline.
// ----------------------------------------------------------------------------
package rpr_pkg;

    localparam int COORD_BITS = 32;
    localparam int GAP_BITS   = COORD_BITS + 1;

    localparam logic signed [COORD_BITS-1:0] EMPTY_LO = COORD_BITS'(1);
    localparam logic signed [COORD_BITS-1:0] EMPTY_HI = {COORD_BITS{1'b1}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [GAP_BITS-1:0]          gap_t;

    typedef struct packed {
        coord_t a_left;
        coord_t a_bottom;
        coord_t a_right;
        coord_t a_top;
        coord_t b_left;
        coord_t b_bottom;
        coord_t b_right;
        coord_t b_top;
    } pair_t;

    typedef struct packed {
        coord_t union_left;
        coord_t union_bottom;
        coord_t union_right;
        coord_t union_top;
        coord_t meet_left;
        coord_t meet_bottom;
        coord_t meet_right;
        coord_t meet_top;
        logic   overlaps;
        logic   a_holds_b;
        gap_t   gap_distance;
        logic   gap_valid;
    } rel_t;

    typedef struct packed {
        logic a_empty;
        logic b_empty;
        logic x_lo_a_less;
        logic x_lo_b_less;
        logic x_hi_a_more;
        logic x_hi_b_more;
        logic x_b_right;
        logic x_a_right;
        logic y_lo_a_less;
        logic y_lo_b_less;
        logic y_hi_a_more;
        logic y_hi_b_more;
        logic y_b_above;
        logic y_a_above;
    } cmp_t;

    typedef struct packed {
        pair_t pair;
        cmp_t  cmp;
    } stg1_t;

    typedef struct packed {
        rel_t rel;
        gap_t dx;
        gap_t dy;
    } stg2_t;

endpackage

// ===== rtl/rpr_compare.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation compare stage
// Registers the box pair with every coordinate comparison the later
// stages select on.
// ----------------------------------------------------------------------------
module rpr_compare (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           valid,
    input  rpr_pkg::pair_t pair,
    output logic           stg_valid,
    output rpr_pkg::stg1_t stg
);
    import rpr_pkg::*;

    logic  valid_reg;
    stg1_t data_reg;
    stg1_t data_next;

    always_comb
    begin
        data_next.pair = pair;
        data_next.cmp.a_empty = (pair.a_right < pair.a_left) || (pair.a_top < pair.a_bottom);
        data_next.cmp.b_empty = (pair.b_right < pair.b_left) || (pair.b_top < pair.b_bottom);
        data_next.cmp.x_lo_a_less = pair.a_left < pair.b_left;
        data_next.cmp.x_lo_b_less = pair.b_left < pair.a_left;
        data_next.cmp.x_hi_a_more = pair.a_right > pair.b_right;
        data_next.cmp.x_hi_b_more = pair.b_right > pair.a_right;
        data_next.cmp.x_b_right   = pair.b_left > pair.a_right;
        data_next.cmp.x_a_right   = pair.a_left > pair.b_right;
        data_next.cmp.y_lo_a_less = pair.a_bottom < pair.b_bottom;
        data_next.cmp.y_lo_b_less = pair.b_bottom < pair.a_bottom;
        data_next.cmp.y_hi_a_more = pair.a_top > pair.b_top;
        data_next.cmp.y_hi_b_more = pair.b_top > pair.a_top;
        data_next.cmp.y_b_above   = pair.b_bottom > pair.a_top;
        data_next.cmp.y_a_above   = pair.a_bottom > pair.b_top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid)
        begin
            data_reg <= data_next;
        end
    end

    assign stg_valid = valid_reg;
    assign stg       = data_reg;

endmodule

// ===== rtl/rpr_select.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation select stage
// Picks the union and intersection corners, forms the relation flags and
// the per-axis gaps.
// ----------------------------------------------------------------------------
module rpr_select (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           valid,
    input  rpr_pkg::stg1_t stg_in,
    output logic           stg_valid,
    output rpr_pkg::stg2_t stg
);
    import rpr_pkg::*;

    logic  valid_reg;
    stg2_t data_reg;
    stg2_t data_next;
    pair_t p;
    cmp_t  c;
    logic  both;
    logic  ov;

    function automatic gap_t diff(input coord_t hi, input coord_t lo);
        gap_t hx;
        gap_t lx;
        hx = {hi[COORD_BITS-1], hi};
        lx = {lo[COORD_BITS-1], lo};
        return hx - lx;
    endfunction

    always_comb
    begin
        p    = stg_in.pair;
        c    = stg_in.cmp;
        both = !c.a_empty && !c.b_empty;
        ov   = both && !(c.x_b_right || c.x_a_right || c.y_b_above || c.y_a_above);

        if (c.a_empty && c.b_empty)
        begin
            data_next.rel.union_left   = EMPTY_LO;
            data_next.rel.union_bottom = EMPTY_LO;
            data_next.rel.union_right  = EMPTY_HI;
            data_next.rel.union_top    = EMPTY_HI;
        end
        else if (c.a_empty)
        begin
            data_next.rel.union_left   = p.b_left;
            data_next.rel.union_bottom = p.b_bottom;
            data_next.rel.union_right  = p.b_right;
            data_next.rel.union_top    = p.b_top;
        end
        else if (c.b_empty)
        begin
            data_next.rel.union_left   = p.a_left;
            data_next.rel.union_bottom = p.a_bottom;
            data_next.rel.union_right  = p.a_right;
            data_next.rel.union_top    = p.a_top;
        end
        else
        begin
            data_next.rel.union_left   = c.x_lo_a_less ? p.a_left   : p.b_left;
            data_next.rel.union_bottom = c.y_lo_a_less ? p.a_bottom : p.b_bottom;
            data_next.rel.union_right  = c.x_hi_a_more ? p.a_right  : p.b_right;
            data_next.rel.union_top    = c.y_hi_a_more ? p.a_top    : p.b_top;
        end

        if (ov)
        begin
            data_next.rel.meet_left   = c.x_lo_a_less ? p.b_left   : p.a_left;
            data_next.rel.meet_bottom = c.y_lo_a_less ? p.b_bottom : p.a_bottom;
            data_next.rel.meet_right  = c.x_hi_a_more ? p.b_right  : p.a_right;
            data_next.rel.meet_top    = c.y_hi_a_more ? p.b_top    : p.a_top;
        end
        else
        begin
            data_next.rel.meet_left   = EMPTY_LO;
            data_next.rel.meet_bottom = EMPTY_LO;
            data_next.rel.meet_right  = EMPTY_HI;
            data_next.rel.meet_top    = EMPTY_HI;
        end

        data_next.rel.overlaps     = ov;
        data_next.rel.a_holds_b    = both && !c.x_lo_b_less && !c.x_hi_b_more
                                     && !c.y_lo_b_less && !c.y_hi_b_more;
        data_next.rel.gap_distance = '0;
        data_next.rel.gap_valid    = both;

        if (c.x_b_right)
        begin
            data_next.dx = diff(p.b_left, p.a_right);
        end
        else if (c.x_a_right)
        begin
            data_next.dx = diff(p.a_left, p.b_right);
        end
        else
        begin
            data_next.dx = '0;
        end

        if (c.y_b_above)
        begin
            data_next.dy = diff(p.b_bottom, p.a_top);
        end
        else if (c.y_a_above)
        begin
            data_next.dy = diff(p.a_bottom, p.b_top);
        end
        else
        begin
            data_next.dy = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid)
        begin
            data_reg <= data_next;
        end
    end

    assign stg_valid = valid_reg;
    assign stg       = data_reg;

endmodule

// ===== rtl/rpr_gap.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation gap stage
// Adds the axis gaps with saturation (zero when either box is empty) and
// holds the finished transaction in the output register.
// ----------------------------------------------------------------------------
module rpr_gap (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           valid,
    input  rpr_pkg::stg2_t stg_in,
    output logic           rel_valid,
    output rpr_pkg::rel_t  rel_info
);
    import rpr_pkg::*;

    logic              valid_reg;
    rel_t              data_reg;
    rel_t              data_next;
    logic [GAP_BITS:0] sum;

    always_comb
    begin
        sum       = {1'b0, stg_in.dx} + {1'b0, stg_in.dy};
        data_next = stg_in.rel;
        if (!stg_in.rel.gap_valid)
        begin
            data_next.gap_distance = '0;
        end
        else if (sum[GAP_BITS])
        begin
            data_next.gap_distance = '1;
        end
        else
        begin
            data_next.gap_distance = sum[GAP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid)
        begin
            data_reg <= data_next;
        end
    end

    assign rel_valid = valid_reg;
    assign rel_info  = data_reg;

endmodule

// ===== rtl/rectangle_pair_relation_unit.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation unit
// Union, intersection, overlap, containment and Manhattan gap of two
// axis-aligned boxes, in a three-stage pipeline.
//
//   channel   signals                          transaction
//   box       box_valid, box_stall, box_pair   one pair of boxes A and B
//   rel       rel_valid, rel_stall, rel_info   one relation result
//
// One pair per cycle sustained unless rel_stall holds back a result.
// Stages: coordinate compares, corner select and axis gaps, gap sum.
// Each stage loads when it is empty or its contents move on, so bubbles close.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module rectangle_pair_relation_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           box_valid,
    output logic           box_stall,
    input  rpr_pkg::pair_t box_pair,
    output logic           rel_valid,
    input  logic           rel_stall,
    output rpr_pkg::rel_t  rel_info
);
    import rpr_pkg::*;

    logic  s1_valid;
    logic  s2_valid;
    stg1_t s1;
    stg2_t s2;
    logic  adv1;
    logic  adv2;
    logic  adv3;

    assign adv3      = !rel_valid || !rel_stall;
    assign adv2      = !s2_valid || adv3;
    assign adv1      = !s1_valid || adv2;
    assign box_stall = !adv1;

    rpr_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv1),
        .valid     (box_valid),
        .pair      (box_pair),
        .stg_valid (s1_valid),
        .stg       (s1)
    );

    rpr_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv2),
        .valid     (s1_valid),
        .stg_in    (s1),
        .stg_valid (s2_valid),
        .stg       (s2)
    );

    rpr_gap u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv3),
        .valid     (s2_valid),
        .stg_in    (s2),
        .rel_valid (rel_valid),
        .rel_info  (rel_info)
    );

endmodule

// ===== rtl/rpr_checker.sv =====
// ----------------------------------------------------------------------------
// Rectangle pair relation checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "rectangle_pair_relation_unit_defines.svh"

module rpr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           box_valid,
    input logic           box_stall,
    input rpr_pkg::pair_t box_pair,
    input logic           rel_valid,
    input logic           rel_stall,
    input rpr_pkg::rel_t  rel_info
);
    import rpr_pkg::*;

    logic meet_is_empty;
    logic gap_clear;
    logic hold_sound;
    logic unused_in;

    assign meet_is_empty = (rel_info.meet_left == EMPTY_LO)
                           && (rel_info.meet_bottom == EMPTY_LO)
                           && (rel_info.meet_right == EMPTY_HI)
                           && (rel_info.meet_top == EMPTY_HI);
    assign gap_clear     = (rel_info.gap_distance == '0) && !rel_info.overlaps
                           && !rel_info.a_holds_b;
    assign hold_sound    = rel_info.overlaps && (rel_info.gap_distance == '0);
    assign unused_in     = box_valid ^ box_stall ^ (^box_pair);

    `RPR_ASSERT_NEXT(a_rel_hold, clk, rst_n, rel_valid && rel_stall, rel_valid && $stable(rel_info))
    `RPR_ASSERT_ALWAYS(a_gap_zero, clk, rst_n, !rel_valid || rel_info.gap_valid || gap_clear)
    `RPR_ASSERT_ALWAYS(a_meet_empty, clk, rst_n, !rel_valid || rel_info.overlaps || meet_is_empty)
    `RPR_ASSERT_ALWAYS(a_hold_overlap, clk, rst_n, !rel_valid || !rel_info.a_holds_b || hold_sound)

endmodule

bind rectangle_pair_relation_unit rpr_checker u_rpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box_pair  (box_pair),
    .rel_valid (rel_valid),
    .rel_stall (rel_stall),
    .rel_info  (rel_info)
);
